// ===== sv/lrb_pkg.sv =====
// ----------------------------------------------------------------------------
// lrb_pkg: shared types and constants of the link reconnect controller
// event codes, link phase codes, register indexes and field widths
// ----------------------------------------------------------------------------
package lrb_pkg;

   localparam int MAX_TRIES  = 12;
   localparam int TIME_BITS  = 32;

   localparam int CMD_W      = 2;
   localparam int NOW_W      = 32;
   localparam int PHASE_W    = 2;
   localparam int TRIES_W    = 4;
   localparam int BASE_W     = 16;
   localparam int MAX_W      = 27;
   localparam int TIMEOUT_W  = 20;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 27;
   localparam int SHIFT_W    = 4;
   localparam int DELAY_W    = BASE_W + (1 << SHIFT_W) - 1;

   typedef logic [CMD_W-1:0]      cmd_type;
   typedef logic [NOW_W-1:0]      now_type;
   typedef logic [TIME_BITS-1:0]  time_type;
   typedef logic [PHASE_W-1:0]    phase_type;
   typedef logic [TRIES_W-1:0]    tries_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;
   typedef logic [DELAY_W-1:0]    delay_type;

   // event codes
   localparam cmd_type CMD_TICK       = 2'd0;
   localparam cmd_type CMD_CONNECT    = 2'd1;
   localparam cmd_type CMD_DISCONNECT = 2'd2;

   // link phase codes
   localparam phase_type PH_DISC = 2'd0;
   localparam phase_type PH_CONN = 2'd1;
   localparam phase_type PH_UP   = 2'd2;
   localparam phase_type PH_FAIL = 2'd3;

   // register indexes
   localparam csr_idx_type CSR_BACKOFF_BASE = 3'd0;
   localparam csr_idx_type CSR_BACKOFF_MAX  = 3'd1;
   localparam csr_idx_type CSR_TIMEOUT      = 3'd2;
   localparam csr_idx_type CSR_SSID         = 3'd3;
   localparam csr_idx_type CSR_MDNS_EN      = 3'd4;
   localparam csr_idx_type CSR_HOSTNAME     = 3'd5;

   localparam tries_type MAX_TRIES_C = tries_type'(MAX_TRIES);

endpackage

// ===== sv/link_reconnect_backoff_fsm.sv =====
// ----------------------------------------------------------------------------
// link_reconnect_backoff_fsm: link reconnect controller with capped backoff
// tracks link phase, retry count, attempt deadline and next retry time
// ----------------------------------------------------------------------------
// usage
//   req channel: one event transaction (tick, connect, disconnect) carrying
//   the current ms time, radio link status and name-service start status
//   rsp channel: one result transaction per event with the new link state,
//   attempt start/abort strobes, name-service start/stop strobes and the
//   retry count
//   csr port: plain write port, register index i of the register list,
//   written whenever csr_we is high; write only while the block is idle
// timing
//   rsp_valid rises at the first edge after req acceptance: an input register,
//   then one pass of compare/shift/clamp/add logic into the result register
//   throughput is one event per cycle; the state update happens in the same
//   cycle the event moves into the result register
// stall
//   a stalled result holds in the result register while one more event
//   waits in the input register; req_stall rises only when both are full
// reset
//   synchronous, active high; clears both valid flags and the link state
//   (disconnected, zero tries, zero times, name service off) and loads the
//   register defaults 1000 / 60000 / 10000 / 0 / 0 / 0
// ----------------------------------------------------------------------------
module link_reconnect_backoff_fsm (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lrb_pkg::cmd_type       req_cmd,
   input  lrb_pkg::now_type       req_now_ms,
   input  logic                   req_link_up,
   input  logic                   req_mdns_ok,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lrb_pkg::phase_type     rsp_link_state,
   output logic                   rsp_accepted,
   output logic                   rsp_start_attempt,
   output logic                   rsp_abort_attempt,
   output logic                   rsp_mdns_start,
   output logic                   rsp_mdns_stop,
   output lrb_pkg::tries_type     rsp_retry_count,
   // configuration
   input  logic                   csr_we,
   input  lrb_pkg::csr_idx_type   csr_index,
   input  lrb_pkg::csr_data_type  csr_wdata
);
   import lrb_pkg::*;

   // configuration registers
   logic [BASE_W-1:0]    base_ff;
   logic [MAX_W-1:0]     max_ff;
   logic [TIMEOUT_W-1:0] timeout_ff;
   logic                 ssid_ff;
   logic                 mdns_en_ff;
   logic                 host_ff;

   // controller state
   phase_type phase_ff,    phase_in;
   tries_type tries_ff,    tries_in;
   time_type  deadline_ff, deadline_in;
   time_type  next_ff,     next_in;
   logic      mrun_ff,     mrun_in;

   // input register
   logic      s1_valid_ff, s1_valid_in;
   cmd_type   s1_cmd_ff;
   now_type   s1_now_ff;
   logic      s1_link_ff;
   logic      s1_mok_ff;

   // result register
   logic      rsp_valid_ff, rsp_valid_in;
   phase_type o_phase_ff;
   logic      o_acc_ff, o_start_ff, o_abort_ff, o_mstart_ff, o_mstop_ff;
   tries_type o_tries_ff;

   logic      rsp_held;
   logic      advance;
   logic      req_take;

   // per-event working values
   time_type  t_now;
   logic      acc, o_start, o_abort, o_mstart, o_mstop;
   logic      run_connect, run_sched;
   time_type  deadline_diff, retry_diff;
   logic      deadline_due, retry_due;
   tries_type sched_tries;
   logic [SHIFT_W-1:0] shamt;
   delay_type delay_raw;
   logic [MAX_W-1:0]   delay;
   time_type  sched_time;

   // handshake: result register holds while stalled, input register then waits
   assign rsp_held  = rsp_valid_ff & rsp_stall;
   assign advance   = s1_valid_ff & ~rsp_held;
   assign req_stall = s1_valid_ff & rsp_held;
   assign req_take  = req_valid & ~req_stall;

   assign s1_valid_in  = req_take | (s1_valid_ff & rsp_held);
   assign rsp_valid_in = advance | rsp_held;

   // wrap-safe due tests
   assign t_now         = time_type'(s1_now_ff);
   assign deadline_diff = t_now - deadline_ff;
   assign retry_diff    = t_now - next_ff;
   assign deadline_due  = ~deadline_diff[TIME_BITS-1];
   assign retry_due     = ~retry_diff[TIME_BITS-1];

   // event decode and state update
   always_comb begin
      phase_in    = phase_ff;
      tries_in    = tries_ff;
      deadline_in = deadline_ff;
      mrun_in     = mrun_ff;
      acc         = 1'b0;
      o_start     = 1'b0;
      o_abort     = 1'b0;
      o_mstart    = 1'b0;
      o_mstop     = 1'b0;
      run_connect = 1'b0;
      run_sched   = 1'b0;

      case (s1_cmd_ff)
         CMD_TICK: begin
            case (phase_ff)
               PH_UP: begin
                  if (!s1_link_ff) begin
                     // link dropped: stop name service, back off
                     o_mstop  = mrun_ff;
                     mrun_in  = 1'b0;
                     phase_in = PH_DISC;
                     run_sched = 1'b1;
                  end
               end
               PH_CONN: begin
                  if (s1_link_ff) begin
                     phase_in = PH_UP;
                     tries_in = '0;
                     if (!mrun_ff && mdns_en_ff && host_ff && s1_mok_ff) begin
                        mrun_in  = 1'b1;
                        o_mstart = 1'b1;
                     end
                  end else if (deadline_due) begin
                     // attempt timed out
                     o_abort   = 1'b1;
                     phase_in  = PH_DISC;
                     run_sched = 1'b1;
                  end
               end
               default: begin
                  run_connect = retry_due;
               end
            endcase
         end
         CMD_CONNECT: begin
            run_connect = 1'b1;
         end
         CMD_DISCONNECT: begin
            o_abort   = 1'b1;
            o_mstop   = mrun_ff;
            mrun_in   = 1'b0;
            phase_in  = PH_DISC;
            tries_in  = '0;
            run_sched = 1'b1;
         end
         default: begin
         end
      endcase

      // connect procedure
      if (run_connect) begin
         if (!ssid_ff) begin
            phase_in = PH_FAIL;
         end else if (s1_link_ff) begin
            acc      = 1'b1;
            phase_in = PH_UP;
            tries_in = '0;
            if (!mrun_ff && mdns_en_ff && host_ff && s1_mok_ff) begin
               mrun_in  = 1'b1;
               o_mstart = 1'b1;
            end
         end else if (phase_ff == PH_CONN && !deadline_due) begin
            acc = 1'b1;
         end else begin
            acc         = 1'b1;
            phase_in    = PH_CONN;
            o_start     = 1'b1;
            deadline_in = t_now + time_type'(timeout_ff);
            if (tries_ff == '0) begin
               tries_in = tries_type'(1);
            end
         end
      end
   end

   // backoff schedule: base << (tries-1), clamped to the ceiling
   assign sched_tries = tries_in;
   assign shamt       = (sched_tries == '0) ? '0 : SHIFT_W'(sched_tries - tries_type'(1));
   assign delay_raw   = delay_type'(base_ff) << shamt;
   assign delay       = (delay_raw > delay_type'(max_ff)) ? max_ff : MAX_W'(delay_raw);
   assign sched_time  = t_now + time_type'(delay);

   always_comb begin
      next_in = next_ff;
      if (run_sched) begin
         next_in = sched_time;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= BASE_W'(1000);
         max_ff     <= MAX_W'(60000);
         timeout_ff <= TIMEOUT_W'(10000);
         ssid_ff    <= 1'b0;
         mdns_en_ff <= 1'b0;
         host_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BACKOFF_BASE: base_ff    <= csr_wdata[BASE_W-1:0];
            CSR_BACKOFF_MAX:  max_ff     <= csr_wdata[MAX_W-1:0];
            CSR_TIMEOUT:      timeout_ff <= csr_wdata[TIMEOUT_W-1:0];
            CSR_SSID:         ssid_ff    <= csr_wdata[0];
            CSR_MDNS_EN:      mdns_en_ff <= csr_wdata[0];
            CSR_HOSTNAME:     host_ff    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // controller state, updated as an event moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_DISC;
         tries_ff    <= '0;
         deadline_ff <= '0;
         next_ff     <= '0;
         mrun_ff     <= 1'b0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         // schedule bumps the counter up to the cap
         if (run_sched && tries_in < MAX_TRIES_C) begin
            tries_ff <= tries_in + tries_type'(1);
         end else begin
            tries_ff <= tries_in;
         end
         deadline_ff <= deadline_in;
         next_ff     <= next_in;
         mrun_ff     <= mrun_in;
      end
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff  <= req_cmd;
         s1_now_ff  <= req_now_ms;
         s1_link_ff <= req_link_up;
         s1_mok_ff  <= req_mdns_ok;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         o_phase_ff  <= phase_in;
         o_acc_ff    <= acc;
         o_start_ff  <= o_start;
         o_abort_ff  <= o_abort;
         o_mstart_ff <= o_mstart;
         o_mstop_ff  <= o_mstop;
         if (run_sched && tries_in < MAX_TRIES_C) begin
            o_tries_ff <= tries_in + tries_type'(1);
         end else begin
            o_tries_ff <= tries_in;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_link_state    = o_phase_ff;
   assign rsp_accepted      = o_acc_ff;
   assign rsp_start_attempt = o_start_ff;
   assign rsp_abort_attempt = o_abort_ff;
   assign rsp_mdns_start    = o_mstart_ff;
   assign rsp_mdns_stop     = o_mstop_ff;
   assign rsp_retry_count   = o_tries_ff;

endmodule

// ===== sv/lrb_checker.sv =====
// ----------------------------------------------------------------------------
// lrb_checker: port-level checks of the link reconnect controller
// result consistency and response hold under stall
// ----------------------------------------------------------------------------
module lrb_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  lrb_pkg::phase_type     rsp_link_state,
   input  logic                   rsp_accepted,
   input  logic                   rsp_start_attempt,
   input  logic                   rsp_abort_attempt,
   input  logic                   rsp_mdns_start,
   input  lrb_pkg::tries_type     rsp_retry_count
);
   import lrb_pkg::*;

   // stalled response stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // retry count never exceeds the cap
   a_tries_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_retry_count <= MAX_TRIES_C)
      else $error("retry count above cap");

   // a launched attempt leaves the link connecting and accepted
   a_start_conn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_start_attempt |-> rsp_link_state == PH_CONN && rsp_accepted)
      else $error("attempt start without connecting state");

   // link up never comes with an attempt strobe
   a_up_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_link_state == PH_UP |-> !rsp_abort_attempt && !rsp_start_attempt)
      else $error("attempt strobe while link up");

   // name service starts only with the link up and tries cleared
   a_mdns_up: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mdns_start |-> rsp_link_state == PH_UP && rsp_retry_count == '0)
      else $error("name service start outside link up");

endmodule

bind link_reconnect_backoff_fsm lrb_checker u_lrb_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_link_state    (rsp_link_state),
   .rsp_accepted      (rsp_accepted),
   .rsp_start_attempt (rsp_start_attempt),
   .rsp_abort_attempt (rsp_abort_attempt),
   .rsp_mdns_start    (rsp_mdns_start),
   .rsp_retry_count   (rsp_retry_count)
);
